// ===== hdl/scsed_pkg.sv =====
package scsed_pkg;

	// character codes the scanner looks at
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_FS     = 8'h1C;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_SQUOTE = 8'h27;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_SEMI   = 8'h3B;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_X      = 8'h78;

	// escape sequencer phases
	localparam logic [2:0] ESC_NONE = 3'd0;
	localparam logic [2:0] ESC_OCT1 = 3'd1;
	localparam logic [2:0] ESC_OCT2 = 3'd2;
	localparam logic [2:0] ESC_HEX0 = 3'd3;
	localparam logic [2:0] ESC_HEX1 = 3'd4;

	// error codes
	localparam logic [1:0] ERR_NONE   = 2'd0;
	localparam logic [1:0] ERR_UNTERM = 2'd1;
	localparam logic [1:0] ERR_BADESC = 2'd2;

	// configuration register indexes
	localparam logic [1:0] REG_LANG_MODE  = 2'd0;
	localparam logic [1:0] REG_TAB_WIDTH  = 2'd1;
	localparam logic [1:0] REG_PAD_AT_END = 2'd2;

	localparam int OUT_CNT_BITS = 24;

	typedef struct packed {
		logic [7:0]              ch;
		logic [1:0]              err;
		logic                    last;
		logic [OUT_CNT_BITS-1:0] line;
		logic [OUT_CNT_BITS-1:0] col;
	} res_t;

	// {known, decoded char} for the single-character escapes
	function automatic logic [8:0] simple_esc(input logic [7:0] la);
		logic [8:0] r;
		r = 9'd0;
		case (la)
			8'h61:   r = {1'b1, 8'h07};        // a
			8'h62:   r = {1'b1, 8'h08};        // b
			8'h63:   r = {1'b1, CH_FS};        // c
			8'h66:   r = {1'b1, 8'h0C};        // f
			8'h72:   r = {1'b1, 8'h0D};        // r
			8'h6E:   r = {1'b1, 8'h0A};        // n
			8'h74:   r = {1'b1, 8'h09};        // t
			8'h76:   r = {1'b1, 8'h0B};        // v
			CH_TAB, CH_BSLASH, CH_SQUOTE, CH_DQUOTE, CH_SPACE, 8'h3F:
				r = {1'b1, la};
			default: r = 9'd0;
		endcase
		return r;
	endfunction

	function automatic logic is_octal(input logic [7:0] b);
		return b[7:3] == 5'b00110;
	endfunction

	// {valid, digit value}
	function automatic logic [4:0] hex_digit(input logic [7:0] b);
		logic [4:0] r;
		r = 5'd0;
		if (b >= 8'h30 && b <= 8'h39) begin
			r = {1'b1, b[3:0]};
		end else if ((b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46)) begin
			r = {1'b1, 4'(b[3:0] + 4'd9)};
		end
		return r;
	endfunction

endpackage

// ===== hdl/source_comment_strip_escape_decode.sv =====
// Channel  | handshake             | payload
// ---------+-----------------------+--------------------------------------------------
// in       | in_valid / in_stall   | in_byte, end_of_stream
// out      | out_valid / out_stall | out_char, line_number, column_number,
//          |                       | error_code, last_of_run
// cfg      | cfg_valid / cfg_ready | cfg_index, cfg_data (cfg_ready is always high)
//
// One byte per cycle sustained while out_stall is low. A beat sits in the input
// register, is decoded in one pass and lands in a two-entry result buffer.
// Only the end-of-stream beat can give two results; the beat behind it waits
// in the input register while the buffer drains. A result held by
// out_stall keeps the next beat in the input register. Reset clears all scanner
// state and restores the register defaults (C mode, tab width 1, pad on).
module source_comment_strip_escape_decode #(
	parameter int DEPTH_BITS = 8,
	parameter int COUNT_BITS = 24
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  in_byte,
	input  logic        end_of_stream,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  out_char,
	output logic [23:0] line_number,
	output logic [23:0] column_number,
	output logic [1:0]  error_code,
	output logic        last_of_run,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [4:0]  cfg_data
);
	import scsed_pkg::*;

	localparam logic [COUNT_BITS-1:0] CNT_ONE = COUNT_BITS'(1);
	localparam logic [DEPTH_BITS-1:0] DEP_ONE = DEPTH_BITS'(1);

	function automatic logic [COUNT_BITS-1:0] sat_cnt(input logic [COUNT_BITS-1:0] v,
		input logic [COUNT_BITS-1:0] a);
		logic [COUNT_BITS:0] s;
		s = {1'b0, v} + {1'b0, a};
		return s[COUNT_BITS] ? '1 : s[COUNT_BITS-1:0];
	endfunction

	function automatic logic [DEPTH_BITS-1:0] sat_dep(input logic [DEPTH_BITS-1:0] v);
		logic [DEPTH_BITS:0] s;
		s = {1'b0, v} + {1'b0, DEP_ONE};
		return s[DEPTH_BITS] ? '1 : s[DEPTH_BITS-1:0];
	endfunction

	// configuration
	logic       lang_mode_q;
	logic [4:0] tab_width_q;
	logic       pad_at_end_q;

	// input register
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       eos_s1;

	// scanner state
	logic                  held_valid_q, line_cmt_q, dquote_q, squote_q, ended_q;
	logic [7:0]            held_byte_q;
	logic [DEPTH_BITS-1:0] block_depth_q;
	logic [2:0]            esc_phase_q;
	logic [8:0]            esc_value_q;
	logic [COUNT_BITS-1:0] line_q, col_q;

	// result buffer, slot 0 is the head
	res_t       slot_q [2];
	logic [1:0] out_cnt_q;

	logic pop, proc;

	assign cfg_ready = 1'b1;
	assign out_valid = out_cnt_q != 2'd0;
	assign pop       = out_valid && !out_stall;
	// the buffer must have room for this beat's results after this cycle's pop
	assign proc      = valid_s1 && (out_cnt_q == 2'd0 || (out_cnt_q == 2'd1 && pop));
	assign in_stall  = valid_s1 && !proc;

	assign out_char      = slot_q[0].ch;
	assign line_number   = slot_q[0].line;
	assign column_number = slot_q[0].col;
	assign error_code    = slot_q[0].err;
	assign last_of_run   = slot_q[0].last;

	//------------------------------------------------------------------
	// Held-byte processing: the held byte with the incoming byte as
	// lookahead (none on the end-of-stream beat).
	//------------------------------------------------------------------
	logic                  la_ok, cm, rh_nl, rh_inq, rh_eat, rh_emit, rh_consumed;
	logic [7:0]            rh_c, rh_la, rh_ch;
	logic [1:0]            rh_err;
	logic                  rh_lca, rh_dq, rh_sq;
	logic [DEPTH_BITS-1:0] rh_depth;
	logic [COUNT_BITS-1:0] rh_line, rh_col;
	logic [2:0]            rh_phase;
	logic [8:0]            rh_value, rh_sesc;

	always_comb begin
		la_ok    = !eos_s1;
		rh_la    = byte_s1;
		cm       = lang_mode_q;
		rh_c     = held_byte_q;
		rh_sesc  = simple_esc(rh_la);
		rh_nl    = rh_c == CH_LF;
		rh_inq   = dquote_q || squote_q;
		rh_err   = (rh_nl && rh_inq) ? ERR_UNTERM : ERR_NONE;
		rh_col   = sat_cnt(col_q, (rh_c == CH_TAB) ? COUNT_BITS'(tab_width_q) : CNT_ONE);
		rh_line  = line_q;
		rh_lca   = line_cmt_q;
		if (rh_nl) begin
			rh_lca  = 1'b0;
			rh_col  = '0;
			rh_line = sat_cnt(line_q, CNT_ONE);
		end
		rh_depth = block_depth_q;
		// comment openers, only outside comments and quotes
		if (!rh_lca && block_depth_q == '0 && !rh_inq) begin
			if (!cm && rh_c == CH_SEMI) begin
				rh_lca = 1'b1;
			end
			if (cm && rh_c == CH_SLASH && la_ok && rh_la == CH_SLASH) begin
				rh_lca = 1'b1;
			end
			if (cm && rh_c == CH_SLASH && la_ok && rh_la == CH_STAR) begin
				rh_depth = sat_dep(block_depth_q);
			end
		end
		// block close turns into a space
		rh_eat = 1'b0;
		rh_ch  = rh_c;
		if (cm && rh_c == CH_STAR && la_ok && rh_la == CH_SLASH && !rh_lca &&
			rh_depth != '0 && !rh_inq) begin
			rh_depth = rh_depth - DEP_ONE;
			rh_ch    = CH_SPACE;
			rh_eat   = 1'b1;
		end
		rh_dq = dquote_q;
		rh_sq = squote_q;
		if (cm && rh_ch == CH_DQUOTE && !rh_lca && rh_depth == '0 && !rh_sq) begin
			rh_dq = !rh_dq;
		end
		if (cm && rh_ch == CH_SQUOTE && !rh_lca && rh_depth == '0 && !rh_dq) begin
			rh_sq = !rh_sq;
		end

		rh_emit     = 1'b0;
		rh_consumed = rh_eat;
		rh_phase    = esc_phase_q;
		rh_value    = esc_value_q;
		if (rh_c == CH_BSLASH && la_ok && rh_la == CH_LF) begin
			// line splice
			rh_col      = '0;
			rh_line     = sat_cnt(rh_line, CNT_ONE);
			rh_consumed = 1'b1;
		end else if (rh_lca || rh_depth != '0) begin
			rh_emit = 1'b0;
		end else if ((rh_dq || rh_sq) && rh_ch == CH_BSLASH) begin
			rh_col      = sat_cnt(rh_col, (la_ok && rh_la == CH_TAB) ?
				COUNT_BITS'(tab_width_q) : CNT_ONE);
			rh_consumed = 1'b1;
			rh_err      = ERR_NONE;
			if (!la_ok) begin
				rh_emit = 1'b1;
				rh_err  = ERR_BADESC;
			end else if (rh_sesc[8]) begin
				rh_emit = 1'b1;
				rh_ch   = rh_sesc[7:0];
			end else if (is_octal(rh_la)) begin
				rh_value = {6'd0, rh_la[2:0]};
				rh_phase = ESC_OCT1;
			end else if (rh_la == CH_X) begin
				rh_value = 9'd0;
				rh_phase = ESC_HEX0;
			end else begin
				rh_emit = 1'b1;
				rh_err  = ERR_BADESC;
			end
		end else begin
			rh_emit = 1'b1;
		end
	end

	//------------------------------------------------------------------
	// Per-beat step
	//------------------------------------------------------------------
	logic                  n_held_valid, n_line_cmt, n_dquote, n_squote, n_ended;
	logic [7:0]            n_held_byte;
	logic [DEPTH_BITS-1:0] n_block_depth;
	logic [2:0]            n_esc_phase;
	logic [8:0]            n_esc_value, dig_value;
	logic [COUNT_BITS-1:0] n_line, n_col;
	logic                  e0_valid, pad_valid;
	logic [7:0]            e0_ch;
	logic [1:0]            e0_err;
	logic [4:0]            hexd;
	logic [1:0]            n_cnt;
	res_t                  new0, new1;

	always_comb begin
		n_held_valid  = held_valid_q;
		n_held_byte   = held_byte_q;
		n_line_cmt    = line_cmt_q;
		n_block_depth = block_depth_q;
		n_dquote      = dquote_q;
		n_squote      = squote_q;
		n_esc_phase   = esc_phase_q;
		n_esc_value   = esc_value_q;
		n_line        = line_q;
		n_col         = col_q;
		n_ended       = ended_q;
		e0_valid      = 1'b0;
		e0_ch         = esc_value_q[7:0];
		e0_err        = ERR_NONE;
		pad_valid     = 1'b0;
		hexd          = hex_digit(byte_s1);
		dig_value     = 9'd0;

		if (ended_q) begin
			n_ended = 1'b1;
		end else if (eos_s1) begin
			if (esc_phase_q != ESC_NONE) begin
				// flush a pending numeric escape
				e0_valid    = 1'b1;
				n_esc_phase = ESC_NONE;
			end else if (held_valid_q) begin
				n_held_valid  = 1'b0;
				n_line        = rh_line;
				n_col         = rh_col;
				n_line_cmt    = rh_lca;
				n_block_depth = rh_depth;
				n_dquote      = rh_dq;
				n_squote      = rh_sq;
				n_esc_phase   = rh_phase;
				n_esc_value   = rh_value;
				e0_valid      = rh_emit;
				e0_ch         = rh_ch;
				e0_err        = rh_err;
			end
			pad_valid = pad_at_end_q;
			n_ended   = 1'b1;
		end else if (esc_phase_q == ESC_OCT1 || esc_phase_q == ESC_OCT2) begin
			dig_value = {esc_value_q[5:0], byte_s1[2:0]};
			if (is_octal(byte_s1)) begin
				n_esc_value = dig_value;
				if (esc_phase_q == ESC_OCT2) begin
					e0_valid    = 1'b1;
					e0_ch       = dig_value[7:0];
					n_esc_phase = ESC_NONE;
				end else begin
					n_esc_phase = ESC_OCT2;
				end
			end else begin
				// non-digit ends the escape and becomes the held byte
				e0_valid     = 1'b1;
				n_esc_phase  = ESC_NONE;
				n_held_byte  = byte_s1;
				n_held_valid = 1'b1;
			end
		end else if (esc_phase_q == ESC_HEX0 || esc_phase_q == ESC_HEX1) begin
			dig_value = {esc_value_q[4:0], hexd[3:0]};
			if (hexd[4]) begin
				n_esc_value = dig_value;
				if (esc_phase_q == ESC_HEX1) begin
					e0_valid    = 1'b1;
					e0_ch       = dig_value[7:0];
					n_esc_phase = ESC_NONE;
				end else begin
					n_esc_phase = ESC_HEX1;
				end
			end else begin
				e0_valid     = 1'b1;
				n_esc_phase  = ESC_NONE;
				n_held_byte  = byte_s1;
				n_held_valid = 1'b1;
			end
		end else if (held_valid_q) begin
			n_line        = rh_line;
			n_col         = rh_col;
			n_line_cmt    = rh_lca;
			n_block_depth = rh_depth;
			n_dquote      = rh_dq;
			n_squote      = rh_sq;
			n_esc_phase   = rh_phase;
			n_esc_value   = rh_value;
			e0_valid      = rh_emit;
			e0_ch         = rh_ch;
			e0_err        = rh_err;
			if (rh_consumed) begin
				n_held_valid = 1'b0;
			end else begin
				n_held_byte = byte_s1;
			end
		end else begin
			n_held_byte  = byte_s1;
			n_held_valid = 1'b1;
		end

		// all results of a beat carry the counts after the beat
		new0.ch   = e0_valid ? e0_ch : CH_LF;
		new0.err  = e0_valid ? e0_err : ERR_NONE;
		new0.last = !(e0_valid && pad_valid);
		new0.line = OUT_CNT_BITS'(n_line);
		new0.col  = OUT_CNT_BITS'(n_col);
		new1.ch   = CH_LF;
		new1.err  = ERR_NONE;
		new1.last = 1'b1;
		new1.line = OUT_CNT_BITS'(n_line);
		new1.col  = OUT_CNT_BITS'(n_col);
		n_cnt     = {1'b0, e0_valid} + {1'b0, pad_valid};
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lang_mode_q  <= 1'b1;
			tab_width_q  <= 5'd1;
			pad_at_end_q <= 1'b1;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_LANG_MODE:  lang_mode_q  <= cfg_data[0];
				REG_TAB_WIDTH:  tab_width_q  <= cfg_data;
				REG_PAD_AT_END: pad_at_end_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1 <= in_byte;
			eos_s1  <= end_of_stream;
		end
	end

	// scanner state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_valid_q  <= 1'b0;
			held_byte_q   <= 8'd0;
			line_cmt_q    <= 1'b0;
			block_depth_q <= '0;
			dquote_q      <= 1'b0;
			squote_q      <= 1'b0;
			esc_phase_q   <= ESC_NONE;
			esc_value_q   <= 9'd0;
			line_q        <= CNT_ONE;
			col_q         <= '0;
			ended_q       <= 1'b0;
		end else if (proc) begin
			held_valid_q  <= n_held_valid;
			held_byte_q   <= n_held_byte;
			line_cmt_q    <= n_line_cmt;
			block_depth_q <= n_block_depth;
			dquote_q      <= n_dquote;
			squote_q      <= n_squote;
			esc_phase_q   <= n_esc_phase;
			esc_value_q   <= n_esc_value;
			line_q        <= n_line;
			col_q         <= n_col;
			ended_q       <= n_ended;
		end
	end

	// result buffer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_cnt_q <= 2'd0;
		end else if (proc) begin
			out_cnt_q <= n_cnt;
		end else if (pop) begin
			out_cnt_q <= out_cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (proc) begin
			slot_q[0] <= new0;
			slot_q[1] <= new1;
		end else if (pop) begin
			slot_q[0] <= slot_q[1];
		end
	end

	// checks
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_cnt_q != 2'd3)
		else $error("result buffer count out of range");

	a_stall_has_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1)
		else $error("input stalled with empty input register");

	a_held_vs_escape: assert property (@(posedge clk) disable iff (!arst_n)
		!(held_valid_q && esc_phase_q != ESC_NONE))
		else $error("held byte present during numeric escape");

	a_pair_only: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !last_of_run) |-> out_cnt_q == 2'd2)
		else $error("non-final result without its partner");

	a_ended_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		ended_q |=> ended_q)
		else $error("end-of-stream flag dropped");

endmodule
